[rtl/sid_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the segment intersection unit.
// No dependencies; every other file refers to it by scoped names.
package sid_pkg;

   localparam int COORD_W = 24;
   localparam int T_FRAC  = 16;
   localparam int LIMIT_W = 21;

   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int WIDE_W = PROD_W + 1;
   localparam int REM_W  = WIDE_W + 1;
   localparam int Q_W    = T_FRAC + 1;
   localparam int OFF_W  = DIFF_W + Q_W;
   localparam int SUM_W  = DIFF_W + 3;
   localparam int NSTEP  = Q_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

   // Fields that ride along the divider stages.
   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] p1x;
      logic signed [COORD_W-1:0] p1y;
      logic signed [DIFF_W-1:0]  dpx;
      logic signed [DIFF_W-1:0]  dpy;
   } side_type;

endpackage

[rtl/sid_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the segment intersection unit: request, response, register write.
// Depends on sid_pkg.
interface sid_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [sid_pkg::COORD_W-1:0] p1_x;
   logic signed [sid_pkg::COORD_W-1:0] p1_y;
   logic signed [sid_pkg::COORD_W-1:0] p2_x;
   logic signed [sid_pkg::COORD_W-1:0] p2_y;
   logic signed [sid_pkg::COORD_W-1:0] q1_x;
   logic signed [sid_pkg::COORD_W-1:0] q1_y;
   logic signed [sid_pkg::COORD_W-1:0] q2_x;
   logic signed [sid_pkg::COORD_W-1:0] q2_y;
   modport source (output valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
                   input ready);
   modport sink (input valid, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y,
                 output ready);
endinterface

interface sid_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic signed [sid_pkg::COORD_W-1:0] cross_x;
   logic signed [sid_pkg::COORD_W-1:0] cross_y;
   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

interface sid_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sid_pkg::LIMIT_W-1:0]        data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/sid_div_pipe.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
// Depends on sid_pkg.
module sid_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [sid_pkg::REM_W-1:0]     in_rem,
   input  logic [sid_pkg::WIDE_W-1:0]    in_den,
   input  sid_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [sid_pkg::Q_W-1:0]       out_q,
   output sid_pkg::side_type             out_side
);

   localparam int N = sid_pkg::NSTEP;

   logic                          v_ff [N];
   logic [sid_pkg::REM_W-1:0]     r_ff [N];
   logic [sid_pkg::REM_W-1:0]     r_in [N];
   logic [sid_pkg::WIDE_W-1:0]    d_ff [N];
   logic [sid_pkg::Q_W-1:0]       q_ff [N];
   logic [sid_pkg::Q_W-1:0]       q_in [N];
   sid_pkg::side_type             s_ff [N];

   always_comb begin
      logic [sid_pkg::REM_W-1:0] src;
      logic [sid_pkg::REM_W-1:0] rs;
      logic [sid_pkg::REM_W-1:0] dw;
      logic                      ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            src = in_rem;
            rs  = src;
            dw  = {1'b0, in_den};
         end else begin
            src = r_ff[k-1];
            rs  = {src[sid_pkg::REM_W-2:0], 1'b0};
            dw  = {1'b0, d_ff[k-1]};
         end
         ge      = (rs >= dw);
         r_in[k] = ge ? rs - dw : rs;
         if (k == 0) begin
            q_in[k] = {{(sid_pkg::Q_W-1){1'b0}}, ge};
         end else begin
            q_in[k] = {q_ff[k-1][sid_pkg::Q_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < N; k++) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N; k++) begin
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
            d_ff[k] <= (k == 0) ? in_den  : d_ff[(k == 0) ? 0 : k-1];
            s_ff[k] <= (k == 0) ? in_side : s_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_q     = q_ff[N-1];
   assign out_side  = s_ff[N-1];

endmodule

[rtl/segment_intersection_2d_unit.sv]
`timescale 1ns / 1ps
// Top level of the 2D segment intersection unit.
// Depends on sid_pkg, the interfaces in sid_if and the divider sid_div_pipe.
//
// Usage:
//   req_bus carries one segment pair P1-P2, Q1-Q2 per transfer (signed Q16.8).
//   rsp_bus returns one result per pair, in order: hit and the crossing point,
//   which is zero on a miss.
//   csr_bus writes parallel_limit; it is always ready and should be written
//   only while no pair is in flight.
// There are 24 stages:
//   four stages form differences, products, the cross products and their
//   normalized signs, one stage compares, seventeen stages are the restoring
//   divider (one quotient bit each), and two stages scale and place the point.
// Throughput is one pair per cycle while the receiver does not stall; the divider chain sets the depth.
// Reset clears every stage valid bit and sets parallel_limit to 1.
// When the receiver stalls, the whole pipeline holds in place and req_bus.ready
// falls; nothing is dropped or repeated, and bubbles already in the pipe
// stay in place during the stall.
module segment_intersection_2d_unit (
   input  logic        clock,
   input  logic        reset,
   sid_req_if.sink     req_bus,
   sid_rsp_if.source   rsp_bus,
   sid_csr_if.sink     csr_bus
);

   localparam int CW = sid_pkg::COORD_W;
   localparam int DW = sid_pkg::DIFF_W;
   localparam int PW = sid_pkg::PROD_W;
   localparam int WW = sid_pkg::WIDE_W;
   localparam int OW = sid_pkg::OFF_W;
   localparam int SW = sid_pkg::SUM_W;

   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   logic adv;
   logic [sid_pkg::LIMIT_W-1:0] limit_ff;

   // The pipeline moves as a whole whenever the output slot is free or taken.
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sid_pkg::LIMIT_RESET;
      end else if (csr_bus.valid) begin
         limit_ff <= csr_bus.data;
      end
   end

   // Stage 1: coordinate differences.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [DW-1:0] dpx1_ff, dpy1_ff, dqx1_ff, dqy1_ff, ex1_ff, ey1_ff;
   logic signed [CW-1:0] p1x1_ff, p1y1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dpx1_ff <= DW'(req_bus.p2_x) - DW'(req_bus.p1_x);
         dpy1_ff <= DW'(req_bus.p2_y) - DW'(req_bus.p1_y);
         dqx1_ff <= DW'(req_bus.q2_x) - DW'(req_bus.q1_x);
         dqy1_ff <= DW'(req_bus.q2_y) - DW'(req_bus.q1_y);
         ex1_ff  <= DW'(req_bus.p1_x) - DW'(req_bus.q1_x);
         ey1_ff  <= DW'(req_bus.p1_y) - DW'(req_bus.q1_y);
         p1x1_ff <= req_bus.p1_x;
         p1y1_ff <= req_bus.p1_y;
      end
   end

   // Stage 2: the six products of the three cross products.
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   sid_pkg::side_type    s2_ff, s3_ff, s4_ff, s5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_ff <= dqy1_ff * dpx1_ff;
         m1_ff <= dqx1_ff * dpy1_ff;
         m2_ff <= dqx1_ff * ey1_ff;
         m3_ff <= dqy1_ff * ex1_ff;
         m4_ff <= ey1_ff * dpx1_ff;
         m5_ff <= ex1_ff * dpy1_ff;
         s2_ff <= '{hit: 1'b0, p1x: p1x1_ff, p1y: p1y1_ff, dpx: dpx1_ff, dpy: dpy1_ff};
      end
   end

   // Stage 3: denominator and the two numerators.
   logic signed [WW-1:0] den3_ff, tn3_ff, un3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         den3_ff <= WW'(m0_ff) - WW'(m1_ff);
         tn3_ff  <= WW'(m2_ff) - WW'(m3_ff);
         un3_ff  <= WW'(m4_ff) - WW'(m5_ff);
         s3_ff   <= s2_ff;
      end
   end

   // Stage 4: flip all three so that the denominator is nonnegative.
   logic signed [WW-1:0] den4_ff, tn4_ff, un4_ff;
   logic neg3;
   assign neg3 = den3_ff[WW-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         den4_ff <= neg3 ? -den3_ff : den3_ff;
         tn4_ff  <= neg3 ? -tn3_ff  : tn3_ff;
         un4_ff  <= neg3 ? -un3_ff  : un3_ff;
         s4_ff   <= s3_ff;
      end
   end

   // Stage 5: parallel test and the parameter range tests, by comparison only.
   logic [WW-1:0] den5_ff, tn5_ff;
   logic          hit4;

   always_comb begin
      logic [WW-1:0] dmag;
      dmag = den4_ff;
      hit4 = (dmag != '0) && (dmag >= WW'(limit_ff))
          && !tn4_ff[WW-1] && (tn4_ff <= den4_ff)
          && !un4_ff[WW-1] && (un4_ff != '0) && (un4_ff < den4_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den5_ff <= den4_ff;
         tn5_ff  <= tn4_ff;
         s5_ff   <= '{hit: hit4, p1x: s4_ff.p1x, p1y: s4_ff.p1y,
                      dpx: s4_ff.dpx, dpy: s4_ff.dpy};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stages 6 to 22: t = tn / den with T_FRAC fractional bits.
   logic                    vd;
   logic [sid_pkg::Q_W-1:0] tq;
   sid_pkg::side_type       sd;

   sid_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_rem    ({1'b0, tn5_ff}),
      .in_den    (den5_ff),
      .in_side   (s5_ff),
      .out_valid (vd),
      .out_q     (tq),
      .out_side  (sd)
   );

   // Stage 23: scale the magnitude of each direction by t.
   logic                 v23_ff;
   logic [OW-1:0]        ox_ff, oy_ff;
   logic                 nx_ff, ny_ff;
   sid_pkg::side_type    s23_ff;
   logic [DW-1:0]        magx, magy;

   assign magx = sd.dpx[DW-1] ? DW'(-sd.dpx) : DW'(sd.dpx);
   assign magy = sd.dpy[DW-1] ? DW'(-sd.dpy) : DW'(sd.dpy);

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff  <= OW'(magx) * OW'(tq);
         oy_ff  <= OW'(magy) * OW'(tq);
         nx_ff  <= sd.dpx[DW-1];
         ny_ff  <= sd.dpy[DW-1];
         s23_ff <= sd;
      end
   end

   // Stage 24: add or subtract the truncated offset, saturate, zero on a miss.
   logic signed [SW-1:0] sumx, sumy;
   logic signed [SW-1:0] offx, offy;
   logic signed [CW-1:0] cx, cy;

   assign offx = SW'(ox_ff >> sid_pkg::T_FRAC);
   assign offy = SW'(oy_ff >> sid_pkg::T_FRAC);
   assign sumx = nx_ff ? SW'(s23_ff.p1x) - offx : SW'(s23_ff.p1x) + offx;
   assign sumy = ny_ff ? SW'(s23_ff.p1y) - offy : SW'(s23_ff.p1y) + offy;

   always_comb begin
      priority if (sumx > SAT_HI) begin
         cx = CW'(SAT_HI);
      end else if (sumx < SAT_LO) begin
         cx = CW'(SAT_LO);
      end else begin
         cx = CW'(sumx);
      end
      priority if (sumy > SAT_HI) begin
         cy = CW'(SAT_HI);
      end else if (sumy < SAT_LO) begin
         cy = CW'(SAT_LO);
      end else begin
         cy = CW'(sumy);
      end
   end

   logic                 v24_ff;
   logic                 hit_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v23_ff <= 1'b0;
         v24_ff <= 1'b0;
      end else if (adv) begin
         v23_ff <= vd;
         v24_ff <= v23_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= s23_ff.hit;
         cx_ff  <= s23_ff.hit ? cx : '0;
         cy_ff  <= s23_ff.hit ? cy : '0;
      end
   end

   assign rsp_bus.valid   = v24_ff;
   assign rsp_bus.hit     = hit_ff;
   assign rsp_bus.cross_x = cx_ff;
   assign rsp_bus.cross_y = cy_ff;

`ifndef ASSERT_OFF
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.hit |-> rsp_bus.cross_x == '0 && rsp_bus.cross_y == '0)
      else $error("miss result carries a nonzero point");
   a_limit_reset: assert property (@(posedge clock)
      reset |=> limit_ff == sid_pkg::LIMIT_RESET)
      else $error("parallel limit not restored by reset");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v1_ff)
      else $error("accepted pair did not enter the first stage");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v23_ff) && $stable(s23_ff))
      else $error("stage moved during a stall");
`endif

endmodule
